@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands used by the fill unit RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define CRFB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be seen at a rising clock edge outside reset.
`define CRFB_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ src/crfb_pkg.sv @@
// ----------------------------------------------------------------------------
// crfb_pkg
// Shared codes, constants and pixel arithmetic of the rectangle fill engine.
// ----------------------------------------------------------------------------
package crfb_pkg;

  localparam int unsigned CFG_W     = 9;   // width of every config register
  localparam int unsigned COORD_W   = 18;  // signed width for rectangle edges
  localparam int unsigned PADDR_W   = 5;
  localparam int unsigned PDATA_W   = 32;
  localparam int unsigned REG_IDX_W = 3;

  typedef enum logic [1:0] {
    CMD_FILL  = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_RASTER_WIDTH  = 3'd0,
    REG_RASTER_HEIGHT = 3'd1,
    REG_CLIP_LEFT     = 3'd2,
    REG_CLIP_TOP      = 3'd3,
    REG_CLIP_RIGHT    = 3'd4,
    REG_CLIP_BOTTOM   = 3'd5,
    REG_OPACITY       = 3'd6
  } cfg_reg_e;

  localparam logic STATUS_DONE         = 1'b0;
  localparam logic STATUS_OUT_OF_RANGE = 1'b1;

  localparam logic [CFG_W-1:0] RST_RASTER_WIDTH  = 9'd256;
  localparam logic [CFG_W-1:0] RST_RASTER_HEIGHT = 9'd256;
  localparam logic [CFG_W-1:0] RST_CLIP_LEFT     = 9'd0;
  localparam logic [CFG_W-1:0] RST_CLIP_TOP      = 9'd0;
  localparam logic [CFG_W-1:0] RST_CLIP_RIGHT    = 9'd256;
  localparam logic [CFG_W-1:0] RST_CLIP_BOTTOM   = 9'd256;
  localparam logic [CFG_W-1:0] RST_OPACITY       = 9'd256;
  localparam logic [CFG_W-1:0] OPACITY_ONE       = 9'd256;

  localparam logic [7:0]  CHAN_MAX   = 8'hff;
  localparam logic [15:0] ROUND_HALF = 16'd127;

  // Exact v / 255 for v up to 255 * 255 + 127.
  function automatic logic [7:0] div255(input logic [15:0] v);
    logic [16:0] t;
    t = 17'(v) + 17'(v[15:8]) + 17'd1;
    return t[15:8];
  endfunction

  function automatic logic [7:0] premul_channel(input logic [7:0] c, input logic [7:0] a);
    logic [15:0] p;
    p = 16'(c) * 16'(a) + ROUND_HALF;
    return div255(p);
  endfunction

  // Source-over of premultiplied src onto premultiplied dst, per channel.
  function automatic logic [31:0] blend_word(input logic [31:0] dst, input logic [31:0] src);
    logic [7:0]  inv;
    logic [15:0] p;
    logic [8:0]  v;
    logic [31:0] res;
    inv = CHAN_MAX - src[31:24];
    res = '0;
    for (int i = 0; i < 4; i++) begin
      p = 16'(dst[8*i +: 8]) * 16'(inv) + ROUND_HALF;
      v = 9'(src[8*i +: 8]) + 9'(div255(p));
      res[8*i +: 8] = v[8] ? CHAN_MAX : v[7:0];
    end
    return res;
  endfunction

  function automatic logic signed [COORD_W-1:0] smax(input logic signed [COORD_W-1:0] a,
                                                     input logic signed [COORD_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic signed [COORD_W-1:0] smin(input logic signed [COORD_W-1:0] a,
                                                     input logic signed [COORD_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

endpackage

@@ src/clipped_rect_fill_blend_unit.sv @@
// ----------------------------------------------------------------------------
// clipped_rect_fill_blend_unit
// Clipped rectangle fill with premultiplied source-over blend over a frame store.
// ----------------------------------------------------------------------------
// Steps: a fill does one read-modify-write per cycle through the frame store
//   ports for each of its N covered pixels, an empty fill goes to the result,
//   a read fetches one pixel, a clear writes every store entry, one per cycle.
// Throughput: one item at a time; the next item is taken once the result has
//   moved into the output register, which may still be waiting to be taken.
// Reset: config registers return to their defaults, control state clears; the
//   frame store keeps no reset value and must be cleared before it is read.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module clipped_rect_fill_blend_unit #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // command channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       command_i,
  input  logic signed [15:0]               pos_x_i,
  input  logic signed [15:0]               pos_y_i,
  input  logic [15:0]                      rect_width_i,
  input  logic [15:0]                      rect_height_i,
  input  logic [31:0]                      source_color_i,
  // result channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [7:0]                       pixel_blue_o,
  output logic [7:0]                       pixel_green_o,
  output logic [7:0]                       pixel_red_o,
  output logic [7:0]                       pixel_alpha_o,
  output logic                             status_o,
  // configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [crfb_pkg::PADDR_W-1:0]     paddr,
  input  logic [crfb_pkg::PDATA_W-1:0]     pwdata,
  output logic [crfb_pkg::PDATA_W-1:0]     prdata,
  output logic                             pready
);

  localparam int unsigned DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned X_W    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned Y_W    = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned CW     = crfb_pkg::COORD_W;
  localparam int unsigned CFW    = crfb_pkg::CFG_W;

  localparam logic signed [CW-1:0] MAX_W_S = CW'(MAX_WIDTH);
  localparam logic signed [CW-1:0] MAX_H_S = CW'(MAX_HEIGHT);

  // One-hot sequencer states.
  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_SETUP = 9'b000000010,  // clip rectangle, scale alpha
    ST_PREM  = 9'b000000100,  // premultiply color, first row base
    ST_WALK  = 9'b000001000,  // read one pixel per cycle, write back one behind
    ST_DRAIN = 9'b000010000,  // last write-back
    ST_CLEAR = 9'b000100000,  // sweep whole store
    ST_RDMEM = 9'b001000000,  // issue pixel read
    ST_RDCAP = 9'b010000000,  // capture pixel
    ST_DONE  = 9'b100000000   // hand result to output register
  } state_e;

  state_e state_q, state_d;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [CFW-1:0] raster_width_q, raster_height_q;
  logic [CFW-1:0] clip_left_q, clip_top_q, clip_right_q, clip_bottom_q;
  logic [CFW-1:0] opacity_q;
  logic           cfg_write;
  logic [crfb_pkg::REG_IDX_W-1:0] cfg_idx;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign cfg_idx   = paddr[crfb_pkg::PADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raster_width_q  <= crfb_pkg::RST_RASTER_WIDTH;
      raster_height_q <= crfb_pkg::RST_RASTER_HEIGHT;
      clip_left_q     <= crfb_pkg::RST_CLIP_LEFT;
      clip_top_q      <= crfb_pkg::RST_CLIP_TOP;
      clip_right_q    <= crfb_pkg::RST_CLIP_RIGHT;
      clip_bottom_q   <= crfb_pkg::RST_CLIP_BOTTOM;
      opacity_q       <= crfb_pkg::RST_OPACITY;
    end else if (cfg_write) begin
      case (cfg_idx)
        crfb_pkg::REG_RASTER_WIDTH:  raster_width_q  <= pwdata[CFW-1:0];
        crfb_pkg::REG_RASTER_HEIGHT: raster_height_q <= pwdata[CFW-1:0];
        crfb_pkg::REG_CLIP_LEFT:     clip_left_q     <= pwdata[CFW-1:0];
        crfb_pkg::REG_CLIP_TOP:      clip_top_q      <= pwdata[CFW-1:0];
        crfb_pkg::REG_CLIP_RIGHT:    clip_right_q    <= pwdata[CFW-1:0];
        crfb_pkg::REG_CLIP_BOTTOM:   clip_bottom_q   <= pwdata[CFW-1:0];
        crfb_pkg::REG_OPACITY:       opacity_q       <= pwdata[CFW-1:0];
        default: ;  // unmapped address: drop the write
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      crfb_pkg::REG_RASTER_WIDTH:  prdata = crfb_pkg::PDATA_W'(raster_width_q);
      crfb_pkg::REG_RASTER_HEIGHT: prdata = crfb_pkg::PDATA_W'(raster_height_q);
      crfb_pkg::REG_CLIP_LEFT:     prdata = crfb_pkg::PDATA_W'(clip_left_q);
      crfb_pkg::REG_CLIP_TOP:      prdata = crfb_pkg::PDATA_W'(clip_top_q);
      crfb_pkg::REG_CLIP_RIGHT:    prdata = crfb_pkg::PDATA_W'(clip_right_q);
      crfb_pkg::REG_CLIP_BOTTOM:   prdata = crfb_pkg::PDATA_W'(clip_bottom_q);
      crfb_pkg::REG_OPACITY:       prdata = crfb_pkg::PDATA_W'(opacity_q);
      default:                     prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Command holding registers (payload, no reset)
  // --------------------------------------------------------------------------
  logic [1:0]         cmd_q;
  logic signed [15:0] pos_x_q, pos_y_q;
  logic [15:0]        rect_w_q, rect_h_q;
  logic [31:0]        color_q;

  // --------------------------------------------------------------------------
  // Setup: intersect rectangle with clip window and raster
  // --------------------------------------------------------------------------
  logic signed [CW-1:0] px_s, py_s, rw_s, rh_s;
  logic signed [CW-1:0] cl_s, ct_s, cr_s, cb_s;
  logic signed [CW-1:0] rwid_s, rhgt_s, eff_w_s, eff_h_s;
  logic signed [CW-1:0] left_s, top_s, right_s, bottom_s;
  logic                 fill_hit, read_hit;
  logic [CFW-1:0]       op_sat;
  logic [16:0]          alpha_prod;

  assign px_s   = {{(CW-16){pos_x_q[15]}}, pos_x_q};
  assign py_s   = {{(CW-16){pos_y_q[15]}}, pos_y_q};
  assign rw_s   = {{(CW-16){1'b0}}, rect_w_q};
  assign rh_s   = {{(CW-16){1'b0}}, rect_h_q};
  assign cl_s   = {{(CW-CFW){1'b0}}, clip_left_q};
  assign ct_s   = {{(CW-CFW){1'b0}}, clip_top_q};
  assign cr_s   = {{(CW-CFW){1'b0}}, clip_right_q};
  assign cb_s   = {{(CW-CFW){1'b0}}, clip_bottom_q};
  assign rwid_s = {{(CW-CFW){1'b0}}, raster_width_q};
  assign rhgt_s = {{(CW-CFW){1'b0}}, raster_height_q};

  // Raster size in use never exceeds the store geometry.
  assign eff_w_s = (rwid_s > MAX_W_S) ? MAX_W_S : rwid_s;
  assign eff_h_s = (rhgt_s > MAX_H_S) ? MAX_H_S : rhgt_s;

  assign left_s   = crfb_pkg::smax(crfb_pkg::smax(px_s, cl_s), '0);
  assign top_s    = crfb_pkg::smax(crfb_pkg::smax(py_s, ct_s), '0);
  assign right_s  = crfb_pkg::smin(crfb_pkg::smin(px_s + rw_s, cr_s), eff_w_s);
  assign bottom_s = crfb_pkg::smin(crfb_pkg::smin(py_s + rh_s, cb_s), eff_h_s);

  assign fill_hit = (rect_w_q != '0) && (rect_h_q != '0) &&
                    (right_s > left_s) && (bottom_s > top_s);
  assign read_hit = (px_s >= 0) && (py_s >= 0) && (px_s < eff_w_s) && (py_s < eff_h_s);

  // Opacity saturates at fully opaque; scaled alpha rounds to nearest.
  assign op_sat     = (opacity_q > crfb_pkg::OPACITY_ONE) ? crfb_pkg::OPACITY_ONE : opacity_q;
  assign alpha_prod = 17'(color_q[31:24]) * 17'(op_sat) + 17'd128;

  // --------------------------------------------------------------------------
  // Walk state
  // --------------------------------------------------------------------------
  logic [7:0]        sa_q;          // source alpha, opacity-scaled for fills
  logic [31:0]       src_q;         // premultiplied source word
  logic [X_W-1:0]    x_q, left_q, right_q, x_nxt;
  logic [Y_W-1:0]    y_q, bottom_q, y_nxt;
  logic [ADDR_W-1:0] row_base_q, pix_addr, wr_addr_q, clr_addr_q;
  logic              rd_valid_q;    // read data of walked pixel arrives this cycle
  logic              x_last, y_last, clr_last;
  logic [31:0]       res_pix_q;
  logic              res_status_q;
  logic [31:0]       out_pix_q;
  logic              out_status_q, out_valid_q, out_load;

  assign x_nxt    = x_q + X_W'(1);
  assign y_nxt    = y_q + Y_W'(1);
  assign x_last   = (x_nxt == right_q);
  assign y_last   = (y_nxt == bottom_q);
  assign clr_last = (clr_addr_q == ADDR_W'(DEPTH - 1));
  assign pix_addr = row_base_q + ADDR_W'(x_q);
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  // --------------------------------------------------------------------------
  // Frame store
  // --------------------------------------------------------------------------
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr;
  logic [31:0]       ram_wdata, ram_rdata;

  assign ram_re    = (state_q == ST_WALK) || (state_q == ST_RDMEM);
  assign ram_we    = rd_valid_q || (state_q == ST_CLEAR);
  assign ram_waddr = rd_valid_q ? wr_addr_q : clr_addr_q;
  assign ram_wdata = rd_valid_q ? crfb_pkg::blend_word(ram_rdata, src_q) : src_q;

  crfb_frame_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (pix_addr),
    .rdata_o (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SETUP;
      end
      ST_SETUP: begin
        case (cmd_q)
          crfb_pkg::CMD_FILL:  state_d = fill_hit ? ST_PREM : ST_DONE;
          crfb_pkg::CMD_CLEAR: state_d = ST_PREM;
          crfb_pkg::CMD_READ:  state_d = read_hit ? ST_PREM : ST_DONE;
          default:             state_d = ST_DONE;  // unknown command: empty result
        endcase
      end
      ST_PREM: begin
        if (cmd_q == crfb_pkg::CMD_FILL) begin
          state_d = ST_WALK;
        end else if (cmd_q == crfb_pkg::CMD_CLEAR) begin
          state_d = ST_CLEAR;
        end else begin
          state_d = ST_RDMEM;
        end
      end
      ST_WALK: begin
        if (x_last && y_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: state_d = ST_DONE;
      ST_CLEAR: begin
        if (clr_last) state_d = ST_DONE;
      end
      ST_RDMEM: state_d = ST_RDCAP;
      ST_RDCAP: state_d = ST_DONE;
      ST_DONE: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      // Write-back comes in the cycle after the walk read.
      rd_valid_q <= (state_q == ST_WALK);
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_q    <= command_i;
          pos_x_q  <= pos_x_i;
          pos_y_q  <= pos_y_i;
          rect_w_q <= rect_width_i;
          rect_h_q <= rect_height_i;
          color_q  <= source_color_i;
        end
      end
      ST_SETUP: begin
        sa_q         <= (cmd_q == crfb_pkg::CMD_FILL) ? alpha_prod[15:8] : color_q[31:24];
        res_pix_q    <= '0;
        res_status_q <= (cmd_q == crfb_pkg::CMD_READ && !read_hit) ?
                        crfb_pkg::STATUS_OUT_OF_RANGE : crfb_pkg::STATUS_DONE;
        left_q       <= left_s[X_W-1:0];
        right_q      <= right_s[X_W-1:0];
        bottom_q     <= bottom_s[Y_W-1:0];
        if (cmd_q == crfb_pkg::CMD_READ) begin
          x_q <= px_s[X_W-1:0];
          y_q <= py_s[Y_W-1:0];
        end else begin
          x_q <= left_s[X_W-1:0];
          y_q <= top_s[Y_W-1:0];
        end
      end
      ST_PREM: begin
        src_q      <= {sa_q,
                       crfb_pkg::premul_channel(color_q[23:16], sa_q),
                       crfb_pkg::premul_channel(color_q[15:8], sa_q),
                       crfb_pkg::premul_channel(color_q[7:0], sa_q)};
        row_base_q <= ADDR_W'(y_q * MAX_WIDTH);
        clr_addr_q <= '0;
      end
      ST_WALK: begin
        wr_addr_q <= pix_addr;
        if (x_last) begin
          x_q        <= left_q;
          y_q        <= y_nxt;
          row_base_q <= row_base_q + ADDR_W'(MAX_WIDTH);
        end else begin
          x_q <= x_nxt;
        end
      end
      ST_CLEAR: begin
        clr_addr_q <= clr_addr_q + ADDR_W'(1);
      end
      ST_RDCAP: begin
        res_pix_q <= ram_rdata;
      end
      ST_DONE: begin
        if (out_load) begin
          out_pix_q    <= res_pix_q;
          out_status_q <= res_status_q;
        end
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Ports
  // --------------------------------------------------------------------------
  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign pixel_blue_o  = out_pix_q[7:0];
  assign pixel_green_o = out_pix_q[15:8];
  assign pixel_red_o   = out_pix_q[23:16];
  assign pixel_alpha_o = out_pix_q[31:24];
  assign status_o      = out_status_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `CRFB_ASSERT(a_walk_in_rect, (state_q == ST_WALK) |-> (x_q < right_q && y_q < bottom_q), "walk left the clipped rectangle")
  `CRFB_ASSERT(a_rmw_no_overlap, (rd_valid_q && state_q == ST_WALK) |-> (wr_addr_q != pix_addr), "write-back hits the pixel being read")
  `CRFB_ASSERT(a_idle_drained, !in_stall_o |-> !rd_valid_q, "new command taken with a write-back pending")
  `CRFB_NEVER(a_one_writer, rd_valid_q && state_q == ST_CLEAR, "blend and clear both drive the write port")

endmodule

@@ src/crfb_frame_ram.sv @@
// ----------------------------------------------------------------------------
// crfb_frame_ram
// Frame store: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module crfb_frame_ram #(
  parameter int unsigned DEPTH  = 65536,
  parameter int unsigned ADDR_W = 16
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [31:0]       wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [31:0]       rdata_o
);

  logic [31:0] mem_q [DEPTH];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
